// ===== hw/rtl/x86_instruction_length_decoder_unit_assert.svh =====
// Assertion macros for the x86 length decoder.
// Used by the top level; no other dependencies.
`ifndef X86_INSTRUCTION_LENGTH_DECODER_UNIT_ASSERT_SVH
`define X86_INSTRUCTION_LENGTH_DECODER_UNIT_ASSERT_SVH

// Implication checked on every edge outside reset.
`define XILD_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication.
`define XILD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/xild_pkg.sv =====
// Shared types, constants and decode tables for the x86 length decoder.
// No dependencies.
`default_nettype none
package xild_pkg;
  localparam int MAX_LENGTH = 15;
  localparam int WIN_BYTES  = 15;
  localparam int LANES      = 16;  // one lane per candidate prefix count 0..15

  localparam logic [1:0] MODE_16 = 2'd0;
  localparam logic [1:0] MODE_32 = 2'd1;
  localparam logic [1:0] MODE_64 = 2'd2;

  localparam logic [7:0] OP_ESC  = 8'h0F;
  localparam logic [7:0] OP_OPSZ = 8'h66;
  localparam logic [7:0] OP_ADSZ = 8'h67;

  localparam logic [5:0] MN_NONE = 6'd0, MN_ADD = 6'd1, MN_OR = 6'd2, MN_ADC = 6'd3,
    MN_SBB = 6'd4, MN_AND = 6'd5, MN_SUB = 6'd6, MN_XOR = 6'd7, MN_CMP = 6'd8,
    MN_ROL = 6'd9, MN_ROR = 6'd10, MN_RCL = 6'd11, MN_RCR = 6'd12, MN_SHL = 6'd13,
    MN_SHR = 6'd14, MN_SAR = 6'd15, MN_JCC = 6'd16, MN_SETCC = 6'd17,
    MN_CMOVCC = 6'd18, MN_BSWAP = 6'd19, MN_BT = 6'd20, MN_BTS = 6'd21,
    MN_BTR = 6'd22, MN_BTC = 6'd23, MN_BSF = 6'd24, MN_BSR = 6'd25,
    MN_MOVZX = 6'd26, MN_MOVSX = 6'd27, MN_IMUL = 6'd28, MN_CPUID = 6'd29,
    MN_RDTSC = 6'd30, MN_SYSCALL = 6'd31, MN_UD2 = 6'd32, MN_NOP = 6'd33,
    MN_XADD = 6'd34, MN_CMPXCHG = 6'd35, MN_PUSH = 6'd36, MN_POP = 6'd37,
    MN_XCHG = 6'd38, MN_MOV = 6'd39, MN_TEST = 6'd40, MN_LEA = 6'd41,
    MN_CWDE = 6'd42, MN_CDQ = 6'd43, MN_PUSHFD = 6'd44, MN_POPFD = 6'd45,
    MN_PUSHAD = 6'd46, MN_POPAD = 6'd47, MN_RET = 6'd48, MN_LEAVE = 6'd49,
    MN_INT3 = 6'd50, MN_INT = 6'd51, MN_CALL = 6'd52, MN_JMP = 6'd53,
    MN_HLT = 6'd54, MN_CMC = 6'd55, MN_NOT = 6'd56, MN_NEG = 6'd57,
    MN_MUL = 6'd58, MN_DIV = 6'd59, MN_IDIV = 6'd60, MN_INC = 6'd61,
    MN_DEC = 6'd62, MN_UNKNOWN = 6'd63;

  typedef logic [7:0] byte_t;
  typedef byte_t [WIN_BYTES+15:0] bytes_t;  // window, zero padded past the end

  typedef struct packed {
    logic [4:0] len;   // bytes past the lane start, up to 31
    logic [5:0] mn;
    logic [3:0] cc;
  } lane_res_t;

  typedef struct packed {
    logic       is16;
    logic       is64;
    logic       op16;
    logic       ad16;
  } lane_ctl_t;

  function automatic logic [5:0] arith_mn(input logic [2:0] r);
    case (r)
      3'd0: return MN_ADD;  3'd1: return MN_OR;  3'd2: return MN_ADC;
      3'd3: return MN_SBB;  3'd4: return MN_AND; 3'd5: return MN_SUB;
      3'd6: return MN_XOR;  default: return MN_CMP;
    endcase
  endfunction

  function automatic logic [5:0] shift_mn(input logic [2:0] r);
    case (r)
      3'd0: return MN_ROL; 3'd1: return MN_ROR; 3'd2: return MN_RCL;
      3'd3: return MN_RCR; 3'd4: return MN_SHL; 3'd5: return MN_SHR;
      3'd6: return MN_SHL; default: return MN_SAR;
    endcase
  endfunction

  function automatic logic [5:0] unary_mn(input logic [2:0] r);
    case (r)
      3'd0, 3'd1: return MN_TEST; 3'd2: return MN_NOT; 3'd3: return MN_NEG;
      3'd4: return MN_MUL; 3'd5: return MN_IMUL; 3'd6: return MN_DIV;
      default: return MN_IDIV;
    endcase
  endfunction

  function automatic logic [5:0] ff_mn(input logic [2:0] r);
    case (r)
      3'd0: return MN_INC; 3'd1: return MN_DEC; 3'd2, 3'd3: return MN_CALL;
      3'd4, 3'd5: return MN_JMP; 3'd6: return MN_PUSH;
      default: return MN_UNKNOWN;
    endcase
  endfunction

  function automatic logic is_prefix(input byte_t b);
    case (b)
      8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65,
      OP_OPSZ, OP_ADSZ: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/xild_if.sv =====
// Valid/ready channel interfaces for the x86 length decoder.
// No dependencies.
`default_nettype none
interface xild_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] window_low;
  logic [55:0] window_high;
  logic        in_range;
  modport source (output valid, window_low, window_high, in_range, input ready);
  modport sink   (input valid, window_low, window_high, in_range, output ready);
endinterface

interface xild_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] length;
  logic [5:0] mnemonic_code;
  logic [3:0] condition_code;
  modport source (output valid, length, mnemonic_code, condition_code, input ready);
  modport sink   (input valid, length, mnemonic_code, condition_code, output ready);
endinterface

interface xild_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/xild_modrm.sv =====
// ModRM/SIB/displacement sizer: bytes taken by the ModRM operand.
// Depends on xild_pkg.
`default_nettype none
module xild_modrm (
  input  wire xild_pkg::byte_t    modrm,
  input  wire xild_pkg::byte_t    sib,
  input  wire xild_pkg::lane_ctl_t ctl,
  output logic [2:0]              size   // including the ModRM byte, 1..6
);
  logic [1:0] md;
  logic [2:0] rm;
  always_comb begin
    md = modrm[7:6];
    rm = modrm[2:0];
    size = 3'd1;
    if (ctl.ad16 && !ctl.is64) begin
      if (md == 2'd0 && rm == 3'd6) size = 3'd3;
      else if (md == 2'd1) size = 3'd2;
      else if (md == 2'd2) size = 3'd3;
    end else if (md != 2'd3) begin
      if (rm == 3'd4) begin
        if (md == 2'd0 && sib[2:0] == 3'd5) size = 3'd6;
        else if (md == 2'd1) size = 3'd3;
        else if (md == 2'd2) size = 3'd6;
        else size = 3'd2;
      end else if (md == 2'd0 && rm == 3'd5) size = 3'd5;
      else if (md == 2'd1) size = 3'd2;
      else if (md == 2'd2) size = 3'd5;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/xild_lane.sv =====
// One decode lane: sizes the instruction whose REX/opcode starts at the lane's byte.
// Depends on xild_pkg and xild_modrm.
`default_nettype none
module xild_lane (
  input  wire xild_pkg::byte_t [9:0] b,    // bytes from the lane start
  input  wire xild_pkg::lane_ctl_t  ctl,
  output xild_pkg::lane_res_t       res
);
  logic       rex;
  logic       rexw;
  logic [3:0] o;          // opcode offset
  xild_pkg::byte_t op, s, m0, m1, sb0, sb1;
  logic [2:0] msz1, msz2;
  logic [3:0] iv;
  logic [4:0] l1, l2;     // lengths after ModRM for one-byte and 0x0F forms

  assign rex  = ctl.is64 && b[0][7:4] == 4'h4;
  assign rexw = rex && b[0][3];
  always_comb begin
    o   = rex ? 4'd1 : 4'd0;
    op  = b[o];
    s   = b[o + 4'd1];
    m0  = b[o + 4'd1];
    sb0 = b[o + 4'd2];
    m1  = b[o + 4'd2];
    sb1 = b[o + 4'd3];
  end

  xild_modrm u_m1 (.modrm(m0), .sib(sb0), .ctl(ctl), .size(msz1));
  xild_modrm u_m2 (.modrm(m1), .sib(sb1), .ctl(ctl), .size(msz2));

  always_comb begin
    iv = ctl.op16 ? 4'd2 : 4'd4;
    l1 = 5'(o) + 5'd1 + 5'(msz1);
    l2 = 5'(o) + 5'd2 + 5'(msz2);
    res.len = 5'(o) + 5'd1;
    res.mn  = xild_pkg::MN_NONE;
    res.cc  = 4'd0;
    if (op == xild_pkg::OP_ESC) begin
      res.len = 5'(o) + 5'd2;
      if (s[7:4] == 4'h8) begin
        res.mn = xild_pkg::MN_JCC; res.cc = s[3:0]; res.len = 5'(o) + 5'd2 + 5'(iv);
      end else if (s[7:4] == 4'h9) begin
        res.mn = xild_pkg::MN_SETCC; res.cc = s[3:0]; res.len = l2;
      end else if (s[7:4] == 4'h4) begin
        res.mn = xild_pkg::MN_CMOVCC; res.cc = s[3:0]; res.len = l2;
      end else if (s[7:3] == 5'b11001) begin
        res.mn = xild_pkg::MN_BSWAP;
      end else begin
        res.len = l2;
        case (s)
          8'hA3: res.mn = xild_pkg::MN_BT;
          8'hAB: res.mn = xild_pkg::MN_BTS;
          8'hB3: res.mn = xild_pkg::MN_BTR;
          8'hBB: res.mn = xild_pkg::MN_BTC;
          8'hBC: res.mn = xild_pkg::MN_BSF;
          8'hBD: res.mn = xild_pkg::MN_BSR;
          8'hBA: begin
            res.len = l2 + 5'd1;
            case (m1[4:3])
              2'd0: res.mn = xild_pkg::MN_BT;
              2'd1: res.mn = xild_pkg::MN_BTS;
              2'd2: res.mn = xild_pkg::MN_BTR;
              default: res.mn = xild_pkg::MN_BTC;
            endcase
          end
          8'hB6, 8'hB7: res.mn = xild_pkg::MN_MOVZX;
          8'hBE, 8'hBF: res.mn = xild_pkg::MN_MOVSX;
          8'hAF: res.mn = xild_pkg::MN_IMUL;
          8'hA2: begin res.mn = xild_pkg::MN_CPUID; res.len = 5'(o) + 5'd2; end
          8'h31: begin res.mn = xild_pkg::MN_RDTSC; res.len = 5'(o) + 5'd2; end
          8'h05: begin res.mn = xild_pkg::MN_SYSCALL; res.len = 5'(o) + 5'd2; end
          8'h0B: begin res.mn = xild_pkg::MN_UD2; res.len = 5'(o) + 5'd2; end
          8'h1F: res.mn = xild_pkg::MN_NOP;
          8'hC0, 8'hC1: res.mn = xild_pkg::MN_XADD;
          8'hB0, 8'hB1: res.mn = xild_pkg::MN_CMPXCHG;
          8'hA0, 8'hA8: begin res.mn = xild_pkg::MN_PUSH; res.len = 5'(o) + 5'd2; end
          8'hA1, 8'hA9: begin res.mn = xild_pkg::MN_POP; res.len = 5'(o) + 5'd2; end
          default: res.mn = xild_pkg::MN_NONE;
        endcase
      end
    end else if (op < 8'h40 && op[2:0] <= 3'd5) begin
      res.mn = xild_pkg::arith_mn(op[5:3]);
      if (op[2:0] <= 3'd3) res.len = l1;
      else if (op[2:0] == 3'd4) res.len = 5'(o) + 5'd2;
      else res.len = 5'(o) + 5'd1 + 5'(iv);
    end else if (op[7:3] == 5'b01010) res.mn = xild_pkg::MN_PUSH;
    else if (op[7:3] == 5'b01011) res.mn = xild_pkg::MN_POP;
    else if (op[7:4] == 4'h7) begin
      res.mn = xild_pkg::MN_JCC; res.cc = op[3:0]; res.len = 5'(o) + 5'd2;
    end else if (op[7:3] == 5'b10010) begin
      res.mn = (op == 8'h90) ? xild_pkg::MN_NOP : xild_pkg::MN_XCHG;
    end else if (op[7:3] == 5'b10110) begin
      res.mn = xild_pkg::MN_MOV; res.len = 5'(o) + 5'd2;
    end else if (op[7:3] == 5'b10111) begin
      res.mn = xild_pkg::MN_MOV; res.len = 5'(o) + 5'd1 + (rexw ? 5'd8 : 5'(iv));
    end else begin
      case (op)
        8'h80, 8'h83: begin res.mn = xild_pkg::arith_mn(m0[5:3]); res.len = l1 + 5'd1; end
        8'h81: begin res.mn = xild_pkg::arith_mn(m0[5:3]); res.len = l1 + 5'(iv); end
        8'h84, 8'h85: begin res.mn = xild_pkg::MN_TEST; res.len = l1; end
        8'h86, 8'h87: begin res.mn = xild_pkg::MN_XCHG; res.len = l1; end
        8'h88, 8'h89, 8'h8A, 8'h8B: begin res.mn = xild_pkg::MN_MOV; res.len = l1; end
        8'h8D: begin res.mn = xild_pkg::MN_LEA; res.len = l1; end
        8'h8F: begin res.mn = xild_pkg::MN_POP; res.len = l1; end
        8'h98: res.mn = xild_pkg::MN_CWDE;
        8'h99: res.mn = xild_pkg::MN_CDQ;
        8'h9C: res.mn = xild_pkg::MN_PUSHFD;
        8'h9D: res.mn = xild_pkg::MN_POPFD;
        8'h60: res.mn = xild_pkg::MN_PUSHAD;
        8'h61: res.mn = xild_pkg::MN_POPAD;
        8'h68: begin res.mn = xild_pkg::MN_PUSH; res.len = 5'(o) + 5'd1 + 5'(iv); end
        8'h6A: begin res.mn = xild_pkg::MN_PUSH; res.len = 5'(o) + 5'd2; end
        8'h69: begin res.mn = xild_pkg::MN_IMUL; res.len = l1 + 5'(iv); end
        8'h6B: begin res.mn = xild_pkg::MN_IMUL; res.len = l1 + 5'd1; end
        8'hA8: begin res.mn = xild_pkg::MN_TEST; res.len = 5'(o) + 5'd2; end
        8'hA9: begin res.mn = xild_pkg::MN_TEST; res.len = 5'(o) + 5'd1 + 5'(iv); end
        8'hC0, 8'hC1: begin res.mn = xild_pkg::shift_mn(m0[5:3]); res.len = l1 + 5'd1; end
        8'hD0, 8'hD1, 8'hD2, 8'hD3: begin
          res.mn = xild_pkg::shift_mn(m0[5:3]); res.len = l1;
        end
        8'hC2: begin res.mn = xild_pkg::MN_RET; res.len = 5'(o) + 5'd3; end
        8'hC3: res.mn = xild_pkg::MN_RET;
        8'hC6: begin res.mn = xild_pkg::MN_MOV; res.len = l1 + 5'd1; end
        8'hC7: begin res.mn = xild_pkg::MN_MOV; res.len = l1 + 5'(iv); end
        8'hC9: res.mn = xild_pkg::MN_LEAVE;
        8'hCC: res.mn = xild_pkg::MN_INT3;
        8'hCD: begin res.mn = xild_pkg::MN_INT; res.len = 5'(o) + 5'd2; end
        8'hE8: begin res.mn = xild_pkg::MN_CALL; res.len = 5'(o) + 5'd1 + 5'(iv); end
        8'hE9: begin res.mn = xild_pkg::MN_JMP; res.len = 5'(o) + 5'd1 + 5'(iv); end
        8'hEB: begin res.mn = xild_pkg::MN_JMP; res.len = 5'(o) + 5'd2; end
        8'hF4: res.mn = xild_pkg::MN_HLT;
        8'hF5: res.mn = xild_pkg::MN_CMC;
        8'hF6, 8'hF7: begin
          res.mn = xild_pkg::unary_mn(m0[5:3]);
          res.len = l1;
          if (m0[5:4] == 2'd0) res.len = l1 + (op[0] ? 5'(iv) : 5'd1);
        end
        8'hFE: begin
          res.mn = (m0[5:3] == 3'd0) ? xild_pkg::MN_INC : xild_pkg::MN_DEC; res.len = l1;
        end
        8'hFF: begin res.mn = xild_pkg::ff_mn(m0[5:3]); res.len = l1; end
        8'hA0, 8'hA1, 8'hA2, 8'hA3: begin
          res.mn = xild_pkg::MN_MOV;
          if (ctl.is64) res.len = 5'(o) + 5'd1 + (ctl.ad16 ? 5'd4 : 5'd8);
          else res.len = 5'(o) + 5'd1 + (ctl.ad16 ? 5'd2 : 5'd4);
        end
        default: res.mn = xild_pkg::MN_NONE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/x86_instruction_length_decoder_unit.sv =====
// Top level of the x86 instruction length decoder: prefix scan, lanes, merge.
// Depends on xild_pkg, xild_if, xild_lane and the assertion macro header.
//
//  channel | dir | payload                                      | accepted when
//  in      | in  | window_low[63:0] window_high[55:0] in_range  | valid & ready
//  out     | out | length[3:0] mnemonic_code[5:0] cond[3:0]     | valid & ready
//  cfg     | in  | data[1:0] (code_mode)                        | valid & ready
//
// One instruction per transaction; a result is registered on acceptance.
// A new transaction is taken every cycle while the output register is empty
// or being drained (single output stage).
// Sixteen lanes decode in parallel, one per possible prefix count; the merge
// picks the lane at the real end of the prefix run.
// Reset: synchronous active-low rst_n; code_mode returns to 32-bit.
// Stall: out.ready low while a result is held keeps it and blocks in.ready.
`default_nettype none
`include "x86_instruction_length_decoder_unit_assert.svh"
module x86_instruction_length_decoder_unit (
  input  wire       clk,
  input  wire       rst_n,
  xild_in_if.sink   in_ch,
  xild_out_if.source out_ch,
  xild_cfg_if.sink  cfg_ch
);
  logic [1:0] mode_r;
  logic       out_valid_r;
  logic [3:0] len_r, len_nxt;
  logic [5:0] mn_r, mn_nxt;
  logic [3:0] cc_r, cc_nxt;
  logic       in_fire;

  xild_pkg::bytes_t bytes;
  logic [15:0] pre;         // pre[i]: byte i is a prefix
  logic [15:0] op_par, ad_par;
  logic [4:0]  npre;
  logic        is16, is64;
  xild_pkg::lane_ctl_t [xild_pkg::LANES-1:0] ctl;
  xild_pkg::lane_res_t [xild_pkg::LANES-1:0] lres;
  xild_pkg::lane_res_t sel;
  logic [5:0] total;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    bytes = '0;
    for (int i = 0; i < 8; i++) bytes[i] = in_ch.window_low[8*i +: 8];
    for (int i = 0; i < 7; i++) bytes[8+i] = in_ch.window_high[8*i +: 8];
  end

  assign is16 = (mode_r == xild_pkg::MODE_16);
  assign is64 = (mode_r == xild_pkg::MODE_64);

  // prefix run length and running 0x66/0x67 parity per lane start
  always_comb begin
    npre = 5'd15;
    for (int i = 14; i >= 0; i--) begin
      pre[i] = xild_pkg::is_prefix(bytes[i]);
      if (!pre[i]) npre = 5'(i);
    end
    pre[15] = 1'b0;
    op_par[0] = 1'b0;
    ad_par[0] = 1'b0;
    for (int i = 1; i < 16; i++) begin
      op_par[i] = op_par[i-1] ^ (bytes[i-1] == xild_pkg::OP_OPSZ);
      ad_par[i] = ad_par[i-1] ^ (bytes[i-1] == xild_pkg::OP_ADSZ);
    end
  end

  genvar g;
  generate
    for (g = 0; g < xild_pkg::LANES; g++) begin : g_lane
      xild_pkg::byte_t [9:0] lb;
      always_comb begin
        for (int k = 0; k < 10; k++) lb[k] = bytes[g + k];
        ctl[g].is16 = is16;
        ctl[g].is64 = is64;
        ctl[g].op16 = is16 ^ op_par[g];
        ctl[g].ad16 = is16 ^ ad_par[g];
      end
      xild_lane u_lane (.b(lb), .ctl(ctl[g]), .res(lres[g]));
    end
  endgenerate

  // merge: pick the lane at the end of the prefix run, check overall length and in_range
  always_comb begin
    sel = lres[npre[3:0]];
    total = 6'(npre) + 6'(sel.len);
    len_nxt = 4'd1; mn_nxt = xild_pkg::MN_NONE; cc_nxt = 4'd0;
    if (in_ch.in_range && total <= 6'(xild_pkg::MAX_LENGTH)) begin
      len_nxt = total[3:0]; mn_nxt = sel.mn; cc_nxt = sel.cc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= xild_pkg::MODE_32;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) mode_r <= cfg_ch.data;
      if (in_fire) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      len_r <= len_nxt; mn_r <= mn_nxt; cc_r <= cc_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.length         = len_r;
  assign out_ch.mnemonic_code  = mn_r;
  assign out_ch.condition_code = cc_r;

  `XILD_ASSERT_NEXT(a_fire_valid, clk, rst_n, in_fire, out_valid_r)
  `XILD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r && $stable(len_r))
  `XILD_ASSERT_IMPL(a_len_nz, clk, rst_n, out_valid_r, len_r != 4'd0)
  `XILD_ASSERT_IMPL(a_cc_only_cond, clk, rst_n,
    out_valid_r && cc_r != 4'd0,
    mn_r == xild_pkg::MN_JCC || mn_r == xild_pkg::MN_SETCC || mn_r == xild_pkg::MN_CMOVCC)
endmodule
`default_nettype wire
